// ===== rtl/core/rgbhsv_pkg.sv =====
`default_nettype none

package rgbhsv_pkg;

    // Channel width and stage layout
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned REM_W    = 2 * CHAN_W;
    localparam int unsigned QUOT_W   = CHAN_W;
    // Stage 0 sorts the channels, stage 1 scales, then one stage per quotient bit,
    // then the output stage
    localparam int unsigned DIV_BASE = 2;
    localparam int unsigned N_STAGES = DIV_BASE + QUOT_W + 1;

    // Hue circle constants
    localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;
    localparam logic [5:0]        HUE_SECTOR = 6'd43;
    localparam logic [CHAN_W-1:0] HUE_RED    = 8'd0;
    localparam logic [CHAN_W-1:0] HUE_GREEN  = 8'd85;
    localparam logic [CHAN_W-1:0] HUE_BLUE   = 8'd171;

    // Which channel holds the maximum
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // Payload carried from stage to stage
    typedef struct packed {
        t_sector           sector;
        logic              neg;
        logic [CHAN_W-1:0] hi;
        logic [CHAN_W-1:0] chroma;
        logic [REM_W-1:0]  sat_rem;
        logic [REM_W-1:0]  hue_rem;
        logic [QUOT_W-1:0] sat_q;
        logic [QUOT_W-1:0] hue_q;
    } t_item;

endpackage

`default_nettype wire

// ===== rtl/core/rgb_to_hsv_8bit_core.sv =====
`default_nettype none

// Channel   Direction  tdata fields, lowest bit first
// slave     in         red[7:0], green[15:8], blue[23:16]
// master    out        hue[7:0], saturation[15:8], brightness[23:16]
//
// One item per clock is sustained while the master side takes results: two restoring
// dividers run side by side, one quotient bit per stage, over eight stages.
// Each stage holds its item until the next stage is free, so a stall fills
// bubbles first and loses nothing. Reset clears only the valid bits.

module rgb_to_hsv_8bit_core
    import rgbhsv_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // red, green, blue
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata    // hue, saturation, brightness
);

    logic  [N_STAGES-1:0] r_valid;
    t_item                r_item [N_STAGES];
    t_item                n_item [N_STAGES];
    logic  [N_STAGES-1:0] w_vin;
    logic  [N_STAGES-1:0] w_ready;

    // Ready chain: a stage takes a new item when empty or when it hands on
    assign w_ready[N_STAGES-1] = !r_valid[N_STAGES-1] || i_m_tready;
    for (genvar k = 0; k < N_STAGES - 1; k++) begin : g_ready
        assign w_ready[k] = !r_valid[k] || w_ready[k+1];
    end

    assign w_vin[0] = i_s_tvalid;
    for (genvar k = 1; k < N_STAGES; k++) begin : g_vin
        assign w_vin[k] = r_valid[k-1];
    end

    // Stage 0: find max, min, sector and the signed hue difference
    always_comb begin
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] lo;
        logic [CHAN_W-1:0] pa;
        logic [CHAN_W-1:0] pb;
        red   = i_s_tdata[CHAN_W-1:0];
        green = i_s_tdata[2*CHAN_W-1:CHAN_W];
        blue  = i_s_tdata[3*CHAN_W-1:2*CHAN_W];
        n_item[0] = '0;
        if (red >= green && red >= blue) begin
            n_item[0].sector = SEC_RED;
            n_item[0].hi     = red;
            pa = green;
            pb = blue;
        end else if (green >= blue) begin
            n_item[0].sector = SEC_GREEN;
            n_item[0].hi     = green;
            pa = blue;
            pb = red;
        end else begin
            n_item[0].sector = SEC_BLUE;
            n_item[0].hi     = blue;
            pa = red;
            pb = green;
        end
        lo = (red < green) ? red : green;
        lo = (blue < lo) ? blue : lo;
        n_item[0].chroma = n_item[0].hi - lo;
        // Keep the magnitude of the difference, sign apart
        if (pa >= pb) begin
            n_item[0].neg     = 1'b0;
            n_item[0].hue_rem = REM_W'(pa - pb);
        end else begin
            n_item[0].neg     = 1'b1;
            n_item[0].hue_rem = REM_W'(pb - pa);
        end
    end

    // Stage 1: scale both dividends
    always_comb begin
        n_item[1]         = r_item[0];
        n_item[1].sat_rem = REM_W'(r_item[0].chroma) * REM_W'(FULL_SCALE);
        n_item[1].hue_rem = r_item[0].hue_rem[CHAN_W-1:0] * REM_W'(HUE_SECTOR);
        n_item[1].sat_q   = '0;
        n_item[1].hue_q   = '0;
    end

    // Division stages: one quotient bit each, most significant first
    for (genvar j = 0; j < QUOT_W; j++) begin : g_div
        localparam int unsigned BIT = QUOT_W - 1 - j;
        logic [REM_W-1:0] w_sat_sub;
        logic [REM_W-1:0] w_hue_sub;
        assign w_sat_sub = REM_W'(r_item[DIV_BASE+j-1].hi) << BIT;
        assign w_hue_sub = REM_W'(r_item[DIV_BASE+j-1].chroma) << BIT;
        always_comb begin
            n_item[DIV_BASE+j] = r_item[DIV_BASE+j-1];
            if (r_item[DIV_BASE+j-1].sat_rem >= w_sat_sub) begin
                n_item[DIV_BASE+j].sat_rem    = r_item[DIV_BASE+j-1].sat_rem - w_sat_sub;
                n_item[DIV_BASE+j].sat_q[BIT] = 1'b1;
            end
            if (r_item[DIV_BASE+j-1].hue_rem >= w_hue_sub) begin
                n_item[DIV_BASE+j].hue_rem    = r_item[DIV_BASE+j-1].hue_rem - w_hue_sub;
                n_item[DIV_BASE+j].hue_q[BIT] = 1'b1;
            end
        end
    end

    // Output stage: apply sign and sector base, zero hue and saturation for black, hue for grey
    always_comb begin
        t_item             src;
        logic [CHAN_W-1:0] base;
        logic [CHAN_W-1:0] offs;
        src = r_item[N_STAGES-2];
        n_item[N_STAGES-1] = src;
        unique case (src.sector)
            SEC_RED:   base = HUE_RED;
            SEC_GREEN: base = HUE_GREEN;
            SEC_BLUE:  base = HUE_BLUE;
            default:   base = HUE_RED;
        endcase
        offs = src.neg ? (CHAN_W'(0) - src.hue_q) : src.hue_q;
        if (src.hi == '0) begin
            n_item[N_STAGES-1].sat_q = '0;
            n_item[N_STAGES-1].hue_q = '0;
        end else if (src.sat_q == '0) begin
            n_item[N_STAGES-1].hue_q = '0;
        end else begin
            n_item[N_STAGES-1].hue_q = base + offs;
        end
    end

    // Valid bits advance where the stage is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < N_STAGES; k++) begin
                if (w_ready[k]) begin
                    r_valid[k] <= w_vin[k];
                end
            end
        end
    end

    // Payload loads only with a valid item, holds otherwise
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N_STAGES; k++) begin
            if (w_ready[k] && w_vin[k]) begin
                r_item[k] <= n_item[k];
            end
        end
    end

    assign o_s_tready = w_ready[0];
    assign o_m_tvalid = r_valid[N_STAGES-1];
    assign o_m_tdata  = {r_item[N_STAGES-1].hi,
                         r_item[N_STAGES-1].sat_q,
                         r_item[N_STAGES-1].hue_q};

endmodule

`default_nettype wire

// ===== verif/rgb_to_hsv_8bit_core_tb.sv =====
`default_nettype none

module rgb_to_hsv_8bit_core_tb;
    import rgbhsv_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned PHASE_ITEMS  = 340;

    // Result fields in tdata order, brightness in the top byte
    typedef struct packed {
        logic [7:0] brightness;
        logic [7:0] saturation;
        logic [7:0] hue;
    } t_hsv;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;   // red[7:0], green[15:8], blue[23:16]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;   // hue[7:0], saturation[15:8], brightness[23:16]

    t_hsv        hsv_expected[$];
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_request;
    int unsigned pixels_sent;
    int unsigned results_checked;
    int unsigned mismatches;
    int unsigned cycles;

    rgb_to_hsv_8bit_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Work out the HSV triple of one pixel
    function automatic t_hsv hsv_of(input logic [7:0] red, input logic [7:0] green,
                                    input logic [7:0] blue);
        int      hi;
        int      lo;
        int      chroma;
        int      sat;
        int      diff;
        int      base;
        t_sector sector;
        t_hsv    res;
        hi  = int'(red);
        lo  = int'(red);
        res = '0;
        if (int'(green) > hi) hi = int'(green);
        if (int'(blue) > hi)  hi = int'(blue);
        if (int'(green) < lo) lo = int'(green);
        if (int'(blue) < lo)  lo = int'(blue);
        res.brightness = 8'(hi);
        if (hi != 0) begin
            chroma = hi - lo;
            sat = (int'(FULL_SCALE) * chroma) / hi;
            res.saturation = 8'(sat);
            if (sat != 0) begin
                // Red wins ties over green, green over blue
                if (hi == int'(red)) sector = SEC_RED;
                else if (hi == int'(green)) sector = SEC_GREEN;
                else sector = SEC_BLUE;
                case (sector)
                    SEC_RED: begin
                        base = int'(HUE_RED);
                        diff = int'(green) - int'(blue);
                    end
                    SEC_GREEN: begin
                        base = int'(HUE_GREEN);
                        diff = int'(blue) - int'(red);
                    end
                    default: begin
                        base = int'(HUE_BLUE);
                        diff = int'(red) - int'(green);
                    end
                endcase
                // Division truncates toward zero, the sum wraps on the circle
                res.hue = 8'(base + (int'(HUE_SECTOR) * diff) / chroma);
            end
        end
        return res;
    endfunction

    // Offer one pixel, with random idle cycles ahead of it, and wait for the handshake
    task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= 24'($urandom);
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {blue, green, red};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        hsv_expected.push_back(hsv_of(red, green, blue));
        pixels_sent++;
        @(negedge i_clk);
    endtask

    // Pick a pixel: mostly uniform, with greys, tied maxima and extremes mixed in
    task automatic send_random_pixel();
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] top;
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        case ($urandom_range(0, 9))
            0: begin
                g = r;
                b = r;
            end
            1: begin
                top = 8'($urandom_range(1, 255));
                r = top;
                g = top;
                b = 8'($urandom_range(0, top));
            end
            2: begin
                top = 8'($urandom_range(1, 255));
                g = top;
                b = top;
                r = 8'($urandom_range(0, top));
            end
            3: begin
                r = $urandom_range(0, 1) ? 8'hff : 8'h00;
                g = $urandom_range(0, 1) ? 8'hff : 8'h00;
                b = $urandom_range(0, 1) ? 8'hff : 8'h00;
            end
            4: begin
                r = 8'($urandom_range(0, 3));
                g = 8'($urandom_range(0, 3));
                b = 8'($urandom_range(0, 3));
            end
            default: ;
        endcase
        send_pixel(r, g, b);
    endtask

    // Drop the input and wait until every expected result has come out
    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        while (hsv_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic run_random_pixels(input int unsigned count);
        repeat (count) send_random_pixel();
        wait_for_results();
    endtask

    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_pixel(8'd0,   8'd0,   8'd0);     // black
        send_pixel(8'd255, 8'd255, 8'd255);   // white, grey
        send_pixel(8'd128, 8'd128, 8'd128);   // mid grey
        send_pixel(8'd1,   8'd1,   8'd1);     // darkest grey
        send_pixel(8'd255, 8'd0,   8'd0);     // pure red
        send_pixel(8'd0,   8'd255, 8'd0);     // pure green
        send_pixel(8'd0,   8'd0,   8'd255);   // pure blue
        send_pixel(8'd255, 8'd255, 8'd0);     // red ties green
        send_pixel(8'd0,   8'd255, 8'd255);   // green ties blue
        send_pixel(8'd255, 8'd0,   8'd255);   // red ties blue
        send_pixel(8'd200, 8'd50,  8'd100);   // red max, negative offset wraps
        send_pixel(8'd255, 8'd0,   8'd6);     // hue just below the circle top
        send_pixel(8'd255, 8'd0,   8'd1);     // tiny negative offset truncates to zero
        send_pixel(8'd50,  8'd200, 8'd10);    // green max, negative offset
        send_pixel(8'd10,  8'd20,  8'd200);   // blue max, negative offset
        send_pixel(8'd200, 8'd20,  8'd210);   // blue max, positive offset
        send_pixel(8'd1,   8'd0,   8'd0);     // smallest non-black
        send_pixel(8'd1,   8'd1,   8'd0);
        send_pixel(8'd255, 8'd254, 8'd254);   // smallest chroma at full value
        send_pixel(8'd254, 8'd255, 8'd255);
        send_pixel(8'd170, 8'd85,  8'd255);
        wait_for_results();
    endtask

    task automatic test_steady_stream();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_pixels(PHASE_ITEMS);
    endtask

    task automatic test_sparse_input();
        send_idle_pct  = 57;
        recv_stall_pct = 0;
        run_random_pixels(PHASE_ITEMS);
    endtask

    task automatic test_output_stalls();
        send_idle_pct  = 0;
        recv_stall_pct = 57;
        run_random_pixels(PHASE_ITEMS);
    endtask

    task automatic test_mixed_gaps();
        send_idle_pct  = 14;
        recv_stall_pct = 14;
        run_random_pixels(PHASE_ITEMS);
    endtask

    // Hold the output off long enough for the pipeline to fill and block its input
    task automatic test_backpressure_fill();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 300;
        run_random_pixels(60);
    endtask

    // Output ready: random stalls, plus a long hold-off on request
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left != 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Compare each accepted result with the oldest expected triple
    always @(posedge i_clk) begin
        t_hsv want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (hsv_expected.size() == 0) begin
                $error("unexpected result: tdata %h", o_m_tdata);
                mismatches++;
            end else begin
                want = hsv_expected.pop_front();
                results_checked++;
                if (o_m_tdata[7:0] !== want.hue) begin
                    $error("hue: expected %0d, got %0d", want.hue, o_m_tdata[7:0]);
                    mismatches++;
                end
                if (o_m_tdata[15:8] !== want.saturation) begin
                    $error("saturation: expected %0d, got %0d",
                           want.saturation, o_m_tdata[15:8]);
                    mismatches++;
                end
                if (o_m_tdata[23:16] !== want.brightness) begin
                    $error("brightness: expected %0d, got %0d",
                           want.brightness, o_m_tdata[23:16]);
                    mismatches++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, hsv_expected.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_request    = 0;
        pixels_sent     = 0;
        results_checked = 0;
        mismatches      = 0;
        cycles          = 0;
        i_rst_n         = 1'b0;
        i_s_tvalid      = 1'b0;
        i_s_tdata       = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_steady_stream();
        test_sparse_input();
        test_output_stalls();
        test_mixed_gaps();
        test_backpressure_fill();

        if (hsv_expected.size() != 0) begin
            $error("%0d expected results never arrived", hsv_expected.size());
            mismatches++;
        end
        $display("covered black, grey, tied and wrapping hues plus random pixels");
        $display("%0d pixels in, %0d results checked over gap, stall and fill phases",
                 pixels_sent, results_checked);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
